FILE: rtl/wcc_pkg.sv
// Shared types and constants of the window correlation coefficient block.
`timescale 1ns / 1ps
`default_nettype none
package wcc_pkg;

   localparam int PIXEL_W        = 16;
   localparam int CFG_W          = 5;
   localparam int COEF_W         = 16;
   localparam int DEF_MAX_WINDOW = 31;
   localparam int DEF_PIXEL_BITS = 16;

   // ratio of squared covariance to variance product, scaled by 2^32, is at most 2^32
   localparam int FRAC_SHIFT = 32;
   localparam int RATIO_W    = FRAC_SHIFT + 1;
   localparam int ROOT_W     = (RATIO_W + 1) / 2;

   localparam logic [CFG_W-1:0]  SIZE_RESET    = 5'd11;
   localparam logic [COEF_W-1:0] Q15_HUNDREDTH = 16'd328;
   localparam logic [COEF_W-1:0] Q15_MAX       = 16'h7FFF;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] left_pixel;
      logic [PIXEL_W-1:0] right_pixel;
   } req_word_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coefficient;
      logic                     flat_window;
   } rsp_word_type;

   typedef enum logic [2:0] {
      SEL_NSXX,
      SEL_SXSX,
      SEL_NSYY,
      SEL_SYSY,
      SEL_NSXY,
      SEL_SXSY,
      SEL_VXVY,
      SEL_COV2
   } mul_sel_type;

   typedef struct packed {
      logic        accumulate;
      logic        clear_sums;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        div_start;
      logic        sqrt_start;
      logic        load_result;
   } wcc_cmd_type;

   typedef struct packed {
      logic last_item;
      logic flat;
      logic mul_done;
      logic div_done;
      logic sqrt_done;
   } wcc_status_type;

endpackage
`default_nettype wire

FILE: rtl/wcc_datapath.sv
// Datapath: window sums, serial multiplier, divider, square root and result word.
`timescale 1ns / 1ps
`default_nettype none
module wcc_datapath
   import wcc_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_write_en,
   input  wire csr_index_type  csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata,
   input  wire req_word_type   req_data,
   input  wire wcc_cmd_type    cmd,
   output wcc_status_type      status,
   output rsp_word_type        rsp_data
);

   localparam int SIZE_W  = $clog2(MAX_WINDOW + 1);
   localparam int CNT_W   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
   localparam int CMP_W   = 2 * SIZE_W + 1;
   localparam int SUM_W   = PIXEL_BITS + CNT_W;
   localparam int SQ_W    = 2 * PIXEL_BITS + CNT_W;
   localparam int VAR_W   = 2 * SUM_W;
   localparam int PROD_W  = 2 * VAR_W;
   localparam int DCNT_W  = $clog2(RATIO_W + 1);
   localparam int RAD_W   = 2 * ROOT_W;
   localparam int SREM_W  = ROOT_W + 3;
   localparam int SCNT_W  = $clog2(ROOT_W + 1);
   localparam int HIGH_SH = RATIO_W - FRAC_SHIFT;

   logic [CFG_W-1:0]  width_ff, height_ff;
   logic [SIZE_W-1:0] w_eff, h_eff;
   logic [CMP_W-1:0]  target, cnt_next;

   logic [CNT_W-1:0]  count_ff;
   logic [SUM_W-1:0]  sx_ff, sy_ff;
   logic [SQ_W-1:0]   sxx_ff, syy_ff, sxy_ff;
   logic [PIXEL_BITS-1:0] lpix, rpix;
   logic [2*PIXEL_BITS-1:0] lsq, rsq, lr;

   logic [VAR_W-1:0]  n_ext;
   logic [VAR_W-1:0]  op_a, op_b;
   logic [PROD_W-1:0] mul_a_ff, mul_acc_ff;
   logic [VAR_W-1:0]  mul_b_ff;
   logic              mul_busy_ff;
   mul_sel_type       mul_sel_ff;
   logic [VAR_W-1:0]  prod_lo;

   logic [VAR_W-1:0]  tmp_ff, vx_ff, vy_ff, cov_ff;
   logic              neg_ff;
   logic [PROD_W-1:0] pv_ff, cc_ff;

   logic [PROD_W-1:0]  rem_ff;
   logic [RATIO_W-1:0] nlow_ff, quo_ff;
   logic [DCNT_W-1:0]  dcnt_ff;
   logic               div_busy_ff;
   logic [PROD_W:0]    rem_shift, rem_diff;
   logic               rem_ge;

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [SREM_W-1:0] srem_ff, srem_shift, trial;
   logic [SCNT_W-1:0] scnt_ff;
   logic              sqrt_busy_ff;

   logic [ROOT_W:0]   q_sum;
   logic [ROOT_W-1:0] q, q_neg;
   rsp_word_type      rsp_ff, rsp_in;

   // zero counts as one, oversize counts as the largest window
   always_comb begin
      if (width_ff == '0) begin
         w_eff = SIZE_W'(1);
      end else if (int'(width_ff) > MAX_WINDOW) begin
         w_eff = SIZE_W'(MAX_WINDOW);
      end else begin
         w_eff = SIZE_W'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = SIZE_W'(1);
      end else if (int'(height_ff) > MAX_WINDOW) begin
         h_eff = SIZE_W'(MAX_WINDOW);
      end else begin
         h_eff = SIZE_W'(height_ff);
      end
   end

   assign target   = CMP_W'(w_eff) * CMP_W'(h_eff);
   assign cnt_next = CMP_W'(count_ff) + CMP_W'(1);

   assign lpix = req_data.left_pixel[PIXEL_BITS-1:0];
   assign rpix = req_data.right_pixel[PIXEL_BITS-1:0];
   assign lsq  = lpix * lpix;
   assign rsq  = rpix * rpix;
   assign lr   = lpix * rpix;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= SIZE_RESET;
         height_ff <= SIZE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default:    width_ff  <= width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_sums) begin
         count_ff <= '0;
         sx_ff    <= '0;
         sy_ff    <= '0;
         sxx_ff   <= '0;
         syy_ff   <= '0;
         sxy_ff   <= '0;
      end else if (cmd.accumulate) begin
         count_ff <= count_ff + CNT_W'(1);
         sx_ff    <= sx_ff + SUM_W'(lpix);
         sy_ff    <= sy_ff + SUM_W'(rpix);
         sxx_ff   <= sxx_ff + SQ_W'(lsq);
         syy_ff   <= syy_ff + SQ_W'(rsq);
         sxy_ff   <= sxy_ff + SQ_W'(lr);
      end
   end

   // the count goes in as the serial operand so those products finish early
   assign n_ext = VAR_W'(count_ff);

   always_comb begin
      case (cmd.mul_sel)
         SEL_NSXX: begin op_a = VAR_W'(sxx_ff); op_b = n_ext;          end
         SEL_SXSX: begin op_a = VAR_W'(sx_ff);  op_b = VAR_W'(sx_ff);  end
         SEL_NSYY: begin op_a = VAR_W'(syy_ff); op_b = n_ext;          end
         SEL_SYSY: begin op_a = VAR_W'(sy_ff);  op_b = VAR_W'(sy_ff);  end
         SEL_NSXY: begin op_a = VAR_W'(sxy_ff); op_b = n_ext;          end
         SEL_SXSY: begin op_a = VAR_W'(sx_ff);  op_b = VAR_W'(sy_ff);  end
         SEL_VXVY: begin op_a = vx_ff;          op_b = vy_ff;          end
         SEL_COV2: begin op_a = cov_ff;         op_b = cov_ff;         end
         default:  begin op_a = '0;             op_b = '0;             end
      endcase
   end

   assign status.mul_done = mul_busy_ff && (mul_b_ff == '0);
   assign prod_lo         = mul_acc_ff[VAR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
      end else if (cmd.mul_start) begin
         mul_busy_ff <= 1'b1;
      end else if (status.mul_done) begin
         mul_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         mul_a_ff   <= PROD_W'(op_a);
         mul_b_ff   <= op_b;
         mul_acc_ff <= '0;
         mul_sel_ff <= cmd.mul_sel;
      end else if (mul_busy_ff && (mul_b_ff != '0)) begin
         if (mul_b_ff[0]) begin
            mul_acc_ff <= mul_acc_ff + mul_a_ff;
         end
         mul_a_ff <= mul_a_ff << 1;
         mul_b_ff <= mul_b_ff >> 1;
      end
   end

   // variances clip at zero; covariance kept as sign and magnitude
   always_ff @(posedge clock) begin
      if (status.mul_done) begin
         case (mul_sel_ff)
            SEL_NSXX, SEL_NSYY, SEL_NSXY: tmp_ff <= prod_lo;
            SEL_SXSX: vx_ff <= (tmp_ff > prod_lo) ? tmp_ff - prod_lo : '0;
            SEL_SYSY: vy_ff <= (tmp_ff > prod_lo) ? tmp_ff - prod_lo : '0;
            SEL_SXSY: begin
               neg_ff <= prod_lo > tmp_ff;
               cov_ff <= (prod_lo > tmp_ff) ? prod_lo - tmp_ff : tmp_ff - prod_lo;
            end
            SEL_VXVY: pv_ff <= mul_acc_ff;
            SEL_COV2: cc_ff <= mul_acc_ff;
            default:  tmp_ff <= tmp_ff;
         endcase
      end
   end

   assign status.flat = (vx_ff < n_ext) || (vy_ff < n_ext);

   // restoring division of cov^2 * 2^32 by vx*vy; upper part is below the divisor
   assign rem_shift = {rem_ff, nlow_ff[RATIO_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, pv_ff};
   assign rem_diff  = rem_shift - {1'b0, pv_ff};
   assign status.div_done = div_busy_ff && (dcnt_ff == DCNT_W'(RATIO_W));

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
      end else if (status.div_done) begin
         div_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         rem_ff  <= cc_ff >> HIGH_SH;
         nlow_ff <= {cc_ff[HIGH_SH-1:0], {FRAC_SHIFT{1'b0}}};
         quo_ff  <= '0;
         dcnt_ff <= '0;
      end else if (div_busy_ff && !status.div_done) begin
         rem_ff  <= rem_ge ? rem_diff[PROD_W-1:0] : rem_shift[PROD_W-1:0];
         nlow_ff <= nlow_ff << 1;
         quo_ff  <= {quo_ff[RATIO_W-2:0], rem_ge};
         dcnt_ff <= dcnt_ff + DCNT_W'(1);
      end
   end

   // integer square root, two radicand bits per step
   assign srem_shift = {srem_ff[SREM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign trial      = SREM_W'({root_ff, 2'b01});
   assign status.sqrt_done = sqrt_busy_ff && (scnt_ff == SCNT_W'(ROOT_W));

   always_ff @(posedge clock) begin
      if (reset) begin
         sqrt_busy_ff <= 1'b0;
      end else if (cmd.sqrt_start) begin
         sqrt_busy_ff <= 1'b1;
      end else if (status.sqrt_done) begin
         sqrt_busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         rad_ff  <= RAD_W'(quo_ff);
         root_ff <= '0;
         srem_ff <= '0;
         scnt_ff <= '0;
      end else if (sqrt_busy_ff && !status.sqrt_done) begin
         if (srem_shift >= trial) begin
            srem_ff <= srem_shift - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            srem_ff <= srem_shift;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
         rad_ff  <= rad_ff << 2;
         scnt_ff <= scnt_ff + SCNT_W'(1);
      end
   end

   // largest q with 2q-1 <= root
   assign q_sum = {1'b0, root_ff} + (ROOT_W + 1)'(1);
   assign q     = q_sum[ROOT_W:1];
   assign q_neg = ROOT_W'(0) - q;

   always_comb begin
      if (status.flat) begin
         rsp_in.coefficient = Q15_HUNDREDTH;
         rsp_in.flat_window = 1'b1;
      end else if (neg_ff) begin
         rsp_in.coefficient = q_neg[COEF_W-1:0];
         rsp_in.flat_window = 1'b0;
      end else begin
         rsp_in.coefficient = (q > ROOT_W'(Q15_MAX)) ? Q15_MAX : q[COEF_W-1:0];
         rsp_in.flat_window = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.last_item = cnt_next >= target;
   assign rsp_data         = rsp_ff;

endmodule
`default_nettype wire

FILE: rtl/wcc_ctrl.sv
// Controller: handshakes and the sequence of multiply, divide and root steps.
`timescale 1ns / 1ps
`default_nettype none
module wcc_ctrl
   import wcc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   input  wire wcc_status_type status,
   output wcc_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_DONE
   } state_type;

   state_type   state_ff;
   mul_sel_type sel_ff, sel_next;
   logic        stall_ff;
   logic        rsp_valid_ff;
   logic        accept, slot_free, skip_cov;

   assign accept    = req_valid && !stall_ff;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   // a flat window needs no covariance
   assign skip_cov  = (sel_ff == SEL_NSXY) && status.flat;

   always_comb begin
      case (sel_ff)
         SEL_NSXX: sel_next = SEL_SXSX;
         SEL_SXSX: sel_next = SEL_NSYY;
         SEL_NSYY: sel_next = SEL_SYSY;
         SEL_SYSY: sel_next = SEL_NSXY;
         SEL_NSXY: sel_next = SEL_SXSY;
         SEL_SXSY: sel_next = SEL_VXVY;
         SEL_VXVY: sel_next = SEL_COV2;
         default:  sel_next = SEL_NSXX;
      endcase
   end

   always_comb begin
      cmd.accumulate  = accept;
      cmd.mul_start   = (state_ff == ST_MUL_GO) && !skip_cov;
      cmd.mul_sel     = sel_ff;
      cmd.div_start   = state_ff == ST_DIV_GO;
      cmd.sqrt_start  = state_ff == ST_SQRT_GO;
      cmd.load_result = (state_ff == ST_DONE) && slot_free;
      cmd.clear_sums  = cmd.load_result;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= SEL_NSXX;
         stall_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && status.last_item) begin
                  state_ff <= ST_MUL_GO;
                  sel_ff   <= SEL_NSXX;
                  stall_ff <= 1'b1;
               end
            end
            ST_MUL_GO: begin
               state_ff <= skip_cov ? ST_DONE : ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
               if (status.mul_done) begin
                  if (sel_ff == SEL_COV2) begin
                     state_ff <= ST_DIV_GO;
                  end else begin
                     state_ff <= ST_MUL_GO;
                     sel_ff   <= sel_next;
                  end
               end
            end
            ST_DIV_GO:   state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (status.div_done) begin
                  state_ff <= ST_SQRT_GO;
               end
            end
            ST_SQRT_GO:  state_ff <= ST_SQRT_WAIT;
            ST_SQRT_WAIT: begin
               if (status.sqrt_done) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (slot_free) begin
                  state_ff <= ST_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               stall_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall = stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

FILE: rtl/window_correlation_coefficient.sv
// Normalized cross-correlation of two packed pixel windows.
//
// req_data carries one left/right pixel pair per word, row-major. Words are
// taken one per cycle while the block sums pixels, squares and cross
// products. The word that completes a window of width*height pairs (set
// through csr_write_en/csr_index/csr_wdata, both 11 after reset) starts the
// final computation and req_stall goes high until the result word is placed
// in the output register. That computation runs eight products through one
// shift-add multiplier (products that take the pair count as serial operand
// finish sooner), a 33-step divider and a 17-step square root. A flat
// window skips the covariance, the division and the square root. rsp_data
// holds the Q1.15 coefficient and the flat flag; while rsp_valid and
// rsp_stall are both high the word holds and a finished next window waits
// with req_stall high until the output register is free. Reset clears all
// sums and the handshake state; no result is pending after reset.
`timescale 1ns / 1ps
`default_nettype none
module window_correlation_coefficient
   import wcc_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_en,
   input  wire csr_index_type    csr_index,
   input  wire logic [CFG_W-1:0] csr_wdata,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_word_type     req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_word_type          rsp_data
);

   wcc_cmd_type    cmd;
   wcc_status_type status;

   wcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   wcc_datapath #(
      .MAX_WINDOW (MAX_WINDOW),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_data     (req_data),
      .cmd          (cmd),
      .status       (status),
      .rsp_data     (rsp_data)
   );

endmodule
`default_nettype wire
